/* rtl/data_eeprom_controller_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the data EEPROM controller
// Shorthand for clocked concurrent assertions used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DATA_EEPROM_CONTROLLER_CORE_MACROS_SVH
`define DATA_EEPROM_CONTROLLER_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define DEC_ASSERT_RUN(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("data EEPROM controller: run-time check failed");

// Checked at every edge, reset included.
`define DEC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("data EEPROM controller: check failed during or after reset");

`endif

/* rtl/dec_pkg.sv */
// ---------------------------------------------------------------------------
// Data EEPROM controller package
// Command and register codes, unlock constants and shared types.
// ---------------------------------------------------------------------------
package dec_pkg;

	localparam int DEPTH_DEFAULT = 256;

	// Bus commands
	localparam logic [1:0] CMD_REG_WRITE = 2'd0;
	localparam logic [1:0] CMD_REG_READ  = 2'd1;
	localparam logic [1:0] CMD_TICK      = 2'd2;

	// Bus register selects
	localparam logic [1:0] SEL_ADDRESS = 2'd0;
	localparam logic [1:0] SEL_DATA    = 2'd1;
	localparam logic [1:0] SEL_CONTROL = 2'd2;
	localparam logic [1:0] SEL_UNLOCK  = 2'd3;

	// Unlock key bytes
	localparam logic [7:0] UNLOCK_FIRST  = 8'h55;
	localparam logic [7:0] UNLOCK_SECOND = 8'hAA;

	// Control register bit positions
	localparam int CTRL_READ_BIT   = 0;
	localparam int CTRL_WRITE_BIT  = 1;
	localparam int CTRL_ENABLE_BIT = 2;
	localparam int CTRL_ERROR_BIT  = 3;

	localparam logic [15:0] WRITE_TICKS_RESET = 16'd4;

	typedef enum logic [2:0] {
		UNLK_NONE  = 3'b001,
		UNLK_FIRST = 3'b010,
		UNLK_OPEN  = 3'b100
	} unlock_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} cell_ctrl_t;

endpackage

/* rtl/dec_cell_mem.sv */
// ---------------------------------------------------------------------------
// Data EEPROM cell array
// Single-port byte store with a registered read that holds between reads.
// ---------------------------------------------------------------------------
module dec_cell_mem #(
	parameter int DEPTH = dec_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  dec_pkg::cell_ctrl_t      ctrl,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wr_data,
	output logic [7:0]               rd_data
);

	logic [7:0] cells [DEPTH];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			cells[addr] <= wr_data;
		end
	end

	// The read register only changes on a read, so it stands in for the
	// data register until that is next written.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data <= cells[addr];
		end
	end

endmodule

/* rtl/data_eeprom_controller_core.sv */
// ---------------------------------------------------------------------------
// Data EEPROM controller core
// Byte-wide data EEPROM behind address, data, control and unlock registers.
// ---------------------------------------------------------------------------
// Path: a word accepted into the input register has its result strobed from the result register.
// Throughput: one word per cycle; busy stays low, as every word completes
// in the single processing stage between the input and result registers.
// Reset: arst_n clears the registers and control state to zero, the unlock state to
// none and the write cycle length to four ticks; the cell array is not cleared.
// ---------------------------------------------------------------------------
module data_eeprom_controller_core #(
	parameter int DEPTH = dec_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [1:0]  reg_select,
	input  logic [7:0]  write_data,
	// Result channel
	output logic        strobe,
	output logic [7:0]  read_data,
	output logic        write_busy,
	output logic        write_done,
	// Configuration
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data
);

	localparam int IDX_W = $clog2(DEPTH);

	// Reduction steps for the address modulo the depth. An 8-bit address
	// is below sixteen times the smallest depth, so four conditional
	// subtractions of DEPTH*8, *4, *2 and *1 are enough.
	localparam logic [11:0] RED8 = 12'(DEPTH * 8);
	localparam logic [11:0] RED4 = 12'(DEPTH * 4);
	localparam logic [11:0] RED2 = 12'(DEPTH * 2);
	localparam logic [11:0] RED1 = 12'(DEPTH);

	// Input register stage
	logic       valid_s1;
	logic [1:0] command_s1;
	logic [1:0] reg_select_s1;
	logic [7:0] write_data_s1;

	// Architectural state
	logic [15:0]            write_ticks_q;
	logic [7:0]             address_q;
	logic [IDX_W-1:0]       cell_index_q;
	logic [7:0]             data_reg_q;
	logic                   data_pend_q;
	logic                   enable_q;
	logic                   busy_q;
	logic                   error_q;
	dec_pkg::unlock_state_t unlock_q;
	logic [15:0]            ticks_left_q;

	// Result register
	logic       strobe_q;
	logic [7:0] read_data_q;
	logic       write_busy_q;
	logic       write_done_q;

	// Next-state values
	logic [7:0]             address_d;
	logic [IDX_W-1:0]       cell_index_d;
	logic [7:0]             data_reg_d;
	logic                   data_pend_d;
	logic                   enable_d;
	logic                   busy_d;
	logic                   error_d;
	dec_pkg::unlock_state_t unlock_d;
	logic [15:0]            ticks_left_d;
	logic [7:0]             read_data_d;
	logic                   done_d;

	logic [11:0]         reduced;
	logic [7:0]          data_eff;
	logic [7:0]          mem_rd_data;
	logic [15:0]         ticks_reload;
	dec_pkg::cell_ctrl_t mem_ctrl;

	// The block never holds the command channel off.
	assign busy = 1'b0;

	// A read from the cells lands in the memory's read register; until the data
	// register is written again, that register is the data register's value.
	assign data_eff = data_pend_q ? mem_rd_data : data_reg_q;

	// A cycle length of zero behaves as one tick.
	assign ticks_reload = (write_ticks_q == 16'd0) ? 16'd1 : write_ticks_q;

	// Cell index of a newly written address, worked out once at the
	// address write so that the memory path carries no reduction logic.
	always_comb begin
		reduced = {4'b0000, write_data_s1};
		if (reduced >= RED8) begin
			reduced = reduced - RED8;
		end
		if (reduced >= RED4) begin
			reduced = reduced - RED4;
		end
		if (reduced >= RED2) begin
			reduced = reduced - RED2;
		end
		if (reduced >= RED1) begin
			reduced = reduced - RED1;
		end
	end

	// Processing stage: one word against the register state.
	always_comb begin
		address_d    = address_q;
		cell_index_d = cell_index_q;
		data_reg_d   = data_reg_q;
		data_pend_d  = data_pend_q;
		enable_d     = enable_q;
		busy_d       = busy_q;
		error_d      = error_q;
		unlock_d     = unlock_q;
		ticks_left_d = ticks_left_q;
		read_data_d  = 8'h00;
		done_d       = 1'b0;
		mem_ctrl     = '0;

		if (valid_s1) begin
			case (command_s1)
				dec_pkg::CMD_REG_WRITE: begin
					case (reg_select_s1)
						dec_pkg::SEL_UNLOCK: begin
							// The key must arrive as two unlock writes with no other register access between.
							if (write_data_s1 == dec_pkg::UNLOCK_FIRST) begin
								unlock_d = dec_pkg::UNLK_FIRST;
							end else if (write_data_s1 == dec_pkg::UNLOCK_SECOND &&
									unlock_q == dec_pkg::UNLK_FIRST) begin
								unlock_d = dec_pkg::UNLK_OPEN;
							end else begin
								unlock_d = dec_pkg::UNLK_NONE;
							end
						end
						dec_pkg::SEL_CONTROL: begin
							unlock_d = dec_pkg::UNLK_NONE;
							enable_d = write_data_s1[dec_pkg::CTRL_ENABLE_BIT];
							error_d  = write_data_s1[dec_pkg::CTRL_ERROR_BIT];
							if (busy_q) begin
								// Dropping enable during a write aborts it and
								// flags the error.
								if (!write_data_s1[dec_pkg::CTRL_ENABLE_BIT]) begin
									busy_d       = 1'b0;
									ticks_left_d = 16'd0;
									error_d      = 1'b1;
								end
							end else begin
								if (write_data_s1[dec_pkg::CTRL_READ_BIT]) begin
									mem_ctrl.rd_en = 1'b1;
									data_pend_d    = 1'b1;
								end
								if (write_data_s1[dec_pkg::CTRL_WRITE_BIT] &&
										write_data_s1[dec_pkg::CTRL_ENABLE_BIT] &&
										unlock_q == dec_pkg::UNLK_OPEN) begin
									busy_d       = 1'b1;
									ticks_left_d = ticks_reload;
								end
							end
						end
						dec_pkg::SEL_ADDRESS: begin
							unlock_d = dec_pkg::UNLK_NONE;
							if (!busy_q) begin
								address_d    = write_data_s1;
								cell_index_d = reduced[IDX_W-1:0];
							end
						end
						default: begin
							// Data register
							unlock_d = dec_pkg::UNLK_NONE;
							if (!busy_q) begin
								data_reg_d  = write_data_s1;
								data_pend_d = 1'b0;
							end
						end
					endcase
				end
				dec_pkg::CMD_REG_READ: begin
					unlock_d = dec_pkg::UNLK_NONE;
					case (reg_select_s1)
						dec_pkg::SEL_ADDRESS: read_data_d = address_q;
						dec_pkg::SEL_DATA:    read_data_d = data_eff;
						dec_pkg::SEL_CONTROL: read_data_d = {4'b0000, error_q, enable_q,
								busy_q, 1'b0};
						default:              read_data_d = 8'h00;
					endcase
				end
				dec_pkg::CMD_TICK: begin
					if (busy_q) begin
						if (ticks_left_q > 16'd1) begin
							ticks_left_d = ticks_left_q - 16'd1;
						end else begin
							// Last tick of the write cycle: commit the byte.
							ticks_left_d   = 16'd0;
							mem_ctrl.wr_en = 1'b1;
							busy_d         = 1'b0;
							done_d         = 1'b1;
						end
					end
				end
				default: begin
					// Unused command: no state change, zero result.
				end
			endcase
		end
	end

	dec_cell_mem #(
		.DEPTH(DEPTH)
	) u_cells (
		.clk     (clk),
		.ctrl    (mem_ctrl),
		.addr    (cell_index_q),
		.wr_data (data_eff),
		.rd_data (mem_rd_data)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			command_s1    <= command;
			reg_select_s1 <= reg_select;
			write_data_s1 <= write_data;
		end
	end

	// Configuration and register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_ticks_q <= dec_pkg::WRITE_TICKS_RESET;
			address_q     <= 8'h00;
			cell_index_q  <= '0;
			data_reg_q    <= 8'h00;
			data_pend_q   <= 1'b0;
			enable_q      <= 1'b0;
			busy_q        <= 1'b0;
			error_q       <= 1'b0;
			unlock_q      <= dec_pkg::UNLK_NONE;
			ticks_left_q  <= 16'd0;
		end else begin
			if (cfg_write_en) begin
				write_ticks_q <= cfg_write_data;
			end
			address_q    <= address_d;
			cell_index_q <= cell_index_d;
			data_reg_q   <= data_reg_d;
			data_pend_q  <= data_pend_d;
			enable_q     <= enable_d;
			busy_q       <= busy_d;
			error_q      <= error_d;
			unlock_q     <= unlock_d;
			ticks_left_q <= ticks_left_d;
		end
	end

	// Result register: fields are held at zero between strobes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q     <= 1'b0;
			read_data_q  <= 8'h00;
			write_busy_q <= 1'b0;
			write_done_q <= 1'b0;
		end else begin
			strobe_q     <= valid_s1;
			read_data_q  <= valid_s1 ? read_data_d : 8'h00;
			write_busy_q <= valid_s1 && busy_d;
			write_done_q <= valid_s1 && done_d;
		end
	end

	assign strobe     = strobe_q;
	assign read_data  = read_data_q;
	assign write_busy = write_busy_q;
	assign write_done = write_done_q;

endmodule

/* rtl/dec_checker.sv */
// ---------------------------------------------------------------------------
// Data EEPROM controller port checker
// Timing and result consistency seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "data_eeprom_controller_core_macros.svh"

module dec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] read_data,
	input logic       write_busy,
	input logic       write_done
);

	// Every accepted word yields exactly one result, through the input and result registers.
	`DEC_ASSERT_RUN(a_accept_gives_result, (start && !busy) |-> ##2 strobe)
	`DEC_ASSERT_RUN(a_result_has_word, strobe |-> $past(start && !busy, 2))

	// The finishing tick ends the write cycle and carries no read byte.
	`DEC_ASSERT_RUN(a_done_clean, write_done |-> (strobe && !write_busy && read_data == 8'h00))

	// Outside a strobe the result ports rest at zero.
	`DEC_ASSERT_ALWAYS(a_idle_quiet, !strobe |-> (!write_done && !write_busy && read_data == 8'h00))

endmodule

bind data_eeprom_controller_core dec_checker u_dec_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.read_data  (read_data),
	.write_busy (write_busy),
	.write_done (write_done)
);
